>>> sv/sll_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list engine package
// Shared constants, command and status codes, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CMD_W    = 3;
  localparam int STEP_W   = 8;
  localparam int STATUS_W = 2;
  localparam int RANK_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int OUTV_W   = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KTH    = 3'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADSTEP  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,    // waiting for an item
    S_FREE,    // scan for lowest free slot
    S_WALK,    // read node at walk pointer
    S_EVAL,    // compare node just read
    S_LINK1,   // insert: write new node
    S_LINK2,   // insert: patch both neighbors
    S_UNLINK1, // unlink: patch prev side
    S_UNLINK2, // unlink: patch next side
    S_DONE     // present result
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic free_start; // reset free scan pointer
    logic free_step;  // advance free scan
    logic walk_start; // start list walk at head
    logic walk_rd;    // issue node read at walk pointer
    logic walk_adv;   // advance walk pointer to next
    logic link1;
    logic link2;
    logic unlink1;
    logic unlink2;
    logic finish;     // build result into output register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic free_done;  // free scan finished
    logic free_found;
    logic full;
    logic walk_end;   // walk pointer at null or guard expired
    logic stop;       // insert: node does not go before value
    logic match;      // node holds value
    logic kth_hit;    // position divisible by k
    logic k_zero;
    logic out_busy;   // output register still holds a result
  } sts_t;

endpackage

>>> sv/sorted_linked_list_engine.sv
// ----------------------------------------------------------------------------
// Sorted linked list engine
// Fixed-capacity sorted doubly linked list with insert/remove/search/k-th/size.
// ----------------------------------------------------------------------------
// One command is processed at a time. The list walk reads one node at a time
// through the single read port of the node memory. Insert adds the link
// states S_LINK1 and S_LINK2 and a free-slot scan that steps past each used
// slot; each removed node adds the unlink states S_UNLINK1 and S_UNLINK2; a
// match ends the walk early. The result waits in an output register, and the
// next item is not taken until that register can be loaded.
module sorted_linked_list_engine import sll_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,       // order_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,        // command[2:0], value[34:3], step_k[42:35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata        // status, rank, count, out_value, is_empty
);

  logic order_r;
  always_ff @(posedge clk) begin
    if (!rst_n) order_r <= 1'b0;
    else if (cfg_we) order_r <= cfg_wdata;
  end

  ctl_t ctl;
  sts_t sts;
  logic [STATUS_W-1:0] st;
  logic [RANK_W-1:0]   rk;
  logic [COUNT_W-1:0]  ct;
  logic [OUTV_W-1:0]   ov;
  logic                em;

  sll_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .sts, .ctl
  );

  sll_datapath #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk, .rst_n, .order_mode(order_r),
    .in_cmd(in_tdata[2:0]),
    .in_val(VALUE_WIDTH'($signed(in_tdata[34:3]))),
    .in_k(in_tdata[42:35]),
    .ctl, .sts, .out_tvalid, .out_tready,
    .out_status(st), .out_rank(rk), .out_count(ct), .out_val(ov), .out_empty(em)
  );

  assign out_tdata = {4'd0, em, ov, ct, rk, st};

endmodule

>>> sv/sll_datapath.sv
// ----------------------------------------------------------------------------
// Sorted list datapath
// Node memories, head/tail, free map, walk pointer and result register.
// ----------------------------------------------------------------------------
module sll_datapath import sll_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   order_mode,
  input  logic [CMD_W-1:0]       in_cmd,
  input  logic [VALUE_WIDTH-1:0] in_val,
  input  logic [STEP_W-1:0]      in_k,
  input  ctl_t                   ctl,
  output sts_t                   sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [STATUS_W-1:0]    out_status,
  output logic [RANK_W-1:0]      out_rank,
  output logic [COUNT_W-1:0]     out_count,
  output logic [OUTV_W-1:0]      out_val,
  output logic                   out_empty
);

  localparam int IW = $clog2(CAPACITY + 1);   // index incl. null marker
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NULL_IX = IW'(CAPACITY);

  logic [VALUE_WIDTH-1:0] mem_val [CAPACITY];
  logic [IW-1:0]          mem_nxt [CAPACITY];
  logic [IW-1:0]          mem_prv [CAPACITY];

  logic [CAPACITY-1:0]    used_r, used_nxt;
  logic [IW-1:0]          head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;

  logic [CMD_W-1:0]       cmd_r;
  logic [VALUE_WIDTH-1:0] v_r;
  logic [STEP_W-1:0]      k_r;
  logic [IW-1:0]          free_r;      // scan pointer, then chosen slot
  logic                   free_ok;
  logic [IW-1:0]          walk_r;
  logic [CW-1:0]          guard_r;
  logic [RANK_W-1:0]      rank_r;
  logic [STEP_W-1:0]      phase_r;     // position mod k
  logic [CW-1:0]          removed_r;
  logic [VALUE_WIDTH-1:0] rem_val_r;

  // registered node read
  logic [VALUE_WIDTH-1:0] rd_val_r;
  logic [IW-1:0]          rd_nxt_r, rd_prv_r;

  logic                   ovalid_r;

  // ordering compare, signed
  logic ge, le, goes_first;
  assign le         = $signed(rd_val_r) <= $signed(v_r);
  assign ge         = $signed(rd_val_r) >= $signed(v_r);
  assign goes_first = order_mode ? ge : le;

  logic [STEP_W-1:0] phase_inc;
  assign phase_inc = phase_r + STEP_W'(1);

  assign sts.cmd        = cmd_r;
  assign sts.free_done  = (free_r == NULL_IX) || !used_r[free_r[AW-1:0]];
  assign sts.free_found = (free_r != NULL_IX);
  assign sts.full       = (free_r == NULL_IX) || (cnt_r >= CW'(CAPACITY));
  assign sts.walk_end   = (walk_r == NULL_IX) || (guard_r >= CW'(CAPACITY));
  assign sts.stop       = !goes_first;
  assign sts.match      = (rd_val_r == v_r);
  assign sts.kth_hit    = (phase_inc == k_r);
  assign sts.k_zero     = (k_r == '0);
  assign sts.out_busy   = ovalid_r;

  // insert: predecessor of the new node (registered read, or tail at list end)
  logic [IW-1:0] ins_prev;
  assign ins_prev = (walk_r == NULL_IX) ? tail_r : rd_prv_r;

  // neighbors of the new node, held for the S_LINK2 patch
  logic [IW-1:0] succ_r;
  logic [IW-1:0] link_prev_r;
  always_ff @(posedge clk) begin
    if (ctl.link1) begin
      succ_r      <= walk_r;
      link_prev_r <= ins_prev;
    end
  end

  // node memories: one read port; link2 patches both neighbors
  always_ff @(posedge clk) begin
    if (ctl.walk_rd && walk_r != NULL_IX) begin
      rd_val_r <= mem_val[walk_r[AW-1:0]];
      rd_nxt_r <= mem_nxt[walk_r[AW-1:0]];
      rd_prv_r <= mem_prv[walk_r[AW-1:0]];
    end
    if (ctl.link1) begin
      mem_val[free_r[AW-1:0]] <= v_r;
      mem_prv[free_r[AW-1:0]] <= ins_prev;
      mem_nxt[free_r[AW-1:0]] <= walk_r;
    end else if (ctl.link2) begin
      if (link_prev_r != NULL_IX) mem_nxt[link_prev_r[AW-1:0]] <= free_r;
      if (succ_r != NULL_IX) mem_prv[succ_r[AW-1:0]] <= free_r;
    end else if (ctl.unlink1) begin
      if (rd_prv_r != NULL_IX) mem_nxt[rd_prv_r[AW-1:0]] <= rd_nxt_r;
    end else if (ctl.unlink2) begin
      if (rd_nxt_r != NULL_IX) mem_prv[rd_nxt_r[AW-1:0]] <= rd_prv_r;
    end
  end

  // list bookkeeping
  always_comb begin
    used_nxt = used_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (ctl.link1) begin
      used_nxt[free_r[AW-1:0]] = 1'b1;
      cnt_nxt = cnt_r + CW'(1);
      if (ins_prev == NULL_IX) head_nxt = free_r;
      if (walk_r == NULL_IX)   tail_nxt = free_r;
    end
    if (ctl.unlink1) begin
      used_nxt[walk_r[AW-1:0]] = 1'b0;
      if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
      if (rd_prv_r == NULL_IX) head_nxt = rd_nxt_r;
      if (rd_nxt_r == NULL_IX) tail_nxt = rd_prv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      head_r <= NULL_IX;
      tail_r <= NULL_IX;
      cnt_r  <= '0;
    end else begin
      used_r <= used_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      v_r   <= in_val;
      k_r   <= in_k;
    end
    if (ctl.free_start) free_r <= '0;
    else if (ctl.free_step) free_r <= free_r + IW'(1);
    if (ctl.walk_start) begin
      walk_r    <= head_r;
      guard_r   <= '0;
      rank_r    <= '0;
      phase_r   <= '0;
      removed_r <= '0;
      rem_val_r <= '0;
    end else if (ctl.walk_adv) begin
      walk_r  <= rd_nxt_r;
      guard_r <= guard_r + CW'(1);
      rank_r  <= rank_r + RANK_W'(1);
      phase_r <= sts.kth_hit ? '0 : phase_inc;
    end
    if (ctl.unlink1) begin
      removed_r <= removed_r + CW'(1);
      rem_val_r <= rd_val_r;
    end
  end
  assign free_ok = sts.free_found;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (ctl.finish) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_status <= ST_OK;
      out_rank   <= '0;
      out_count  <= COUNT_W'(cnt_r);
      out_val    <= '0;
      out_empty  <= (cnt_r == '0);
      case (cmd_r)
        CMD_INSERT: if (!free_ok) out_status <= ST_FULL;
        CMD_REMOVE: begin
          if (removed_r == '0) out_status <= ST_NOTFOUND;
          else out_val <= OUTV_W'(rem_val_r);
        end
        CMD_SEARCH: begin
          if (sts.walk_end) out_status <= ST_NOTFOUND;
          else out_rank <= rank_r;
        end
        CMD_KTH: begin
          out_count <= COUNT_W'(removed_r);
          if (k_r == '0) out_status <= ST_BADSTEP;
        end
        default: ;
      endcase
    end
  end
  assign out_tvalid = ovalid_r;

  // assertions
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY)) else $error("count over capacity");
  a_empty_null: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == NULL_IX && tail_r == NULL_IX))
    else $error("empty list with live head");
  a_used_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(cnt_r)) else $error("free map out of step");

endmodule

>>> sv/sll_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted list controller
// Sequences free scan, list walk and relinking for one command at a time.
// ----------------------------------------------------------------------------
module sll_ctrl import sll_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.load       = 1'b1;
          ctl.free_start = 1'b1;
          ctl.walk_start = 1'b1;
          state_nxt      = S_FREE;
        end
      end
      S_FREE: begin
        // only insert needs the free slot; others go to S_WALK or S_DONE
        if (sts.cmd != CMD_INSERT) begin
          state_nxt = S_WALK;
        end else if (sts.free_done) begin
          state_nxt = sts.full ? S_DONE : S_WALK;
        end else begin
          ctl.free_step = 1'b1;
        end
        if (sts.cmd == CMD_KTH && sts.k_zero) state_nxt = S_DONE;
        if (sts.cmd != CMD_INSERT && sts.cmd != CMD_REMOVE &&
            sts.cmd != CMD_SEARCH && sts.cmd != CMD_KTH) state_nxt = S_DONE;
      end
      S_WALK: begin
        if (sts.walk_end) begin
          state_nxt = (sts.cmd == CMD_INSERT) ? S_LINK1 : S_DONE;
        end else begin
          ctl.walk_rd = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_WALK;
        case (sts.cmd)
          CMD_INSERT: if (sts.stop) state_nxt = S_LINK1; else ctl.walk_adv = 1'b1;
          CMD_REMOVE: if (sts.match) state_nxt = S_UNLINK1; else ctl.walk_adv = 1'b1;
          CMD_SEARCH: if (sts.match) state_nxt = S_DONE; else ctl.walk_adv = 1'b1;
          CMD_KTH:    if (sts.kth_hit) state_nxt = S_UNLINK1; else ctl.walk_adv = 1'b1;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_LINK1: begin
        ctl.link1 = 1'b1;
        state_nxt = S_LINK2;
      end
      S_LINK2: begin
        ctl.link2 = 1'b1;
        state_nxt = S_DONE;
      end
      S_UNLINK1: begin
        ctl.unlink1 = 1'b1;
        state_nxt   = S_UNLINK2;
      end
      S_UNLINK2: begin
        ctl.unlink2 = 1'b1;
        if (sts.cmd == CMD_KTH) begin
          ctl.walk_adv = 1'b1;
          state_nxt    = S_WALK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_link_pair: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.link1 |=> ctl.link2) else $error("link sequence broken");
  a_unlink_pair: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.unlink1 |=> ctl.unlink2) else $error("unlink sequence broken");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Sorted list engine testbench
// Drives insert/remove/search/remove-every-k-th/size commands with random
// handshake gaps, predicts each status item with a behavioral sorted list and
// compares every field of every result.
// ----------------------------------------------------------------------------
module testbench;
  import sll_pkg::*;

  localparam int CAP = 16;
  localparam logic [CMD_W-1:0] CMD_SIZE = 3'd4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RANK_W-1:0]   rank;
    logic [COUNT_W-1:0]  count;
    logic [OUTV_W-1:0]   out_value;
    logic                is_empty;
  } status_item_t;

  // behavioral list: values in list order, plus order setting
  logic signed [31:0] list_vals[$];
  logic               descending = 1'b0;
  status_item_t       pending_status[$];
  int                 error_count = 0;
  int                 result_count = 0;
  int                 cmd_count = 0;
  bit                 allow_idle = 1'b1;
  int                 stall_left = 0;

  sorted_linked_list_engine dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  // predict one command's status item and update the list
  function automatic status_item_t apply_command(logic [2:0] cmd, logic signed [31:0] v,
                                                 logic [7:0] k);
    status_item_t r;
    int pos;
    int removed;
    logic signed [31:0] kept[$];
    r = '0;
    pos = -1;
    removed = 0;
    case (cmd)
      CMD_INSERT: begin
        if (list_vals.size() >= CAP) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < list_vals.size() &&
                 (descending ? list_vals[pos] >= v : list_vals[pos] <= v)) pos++;
          list_vals.insert(pos, v);
        end
      end
      CMD_REMOVE, CMD_SEARCH: begin
        foreach (list_vals[i]) if (pos < 0 && list_vals[i] == v) pos = i;
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else if (cmd == CMD_SEARCH) begin
          r.rank = pos[3:0];
        end else begin
          r.out_value = list_vals[pos];
          list_vals.delete(pos);
        end
      end
      CMD_KTH: begin
        if (k == 0) begin
          r.status = ST_BADSTEP;
        end else begin
          foreach (list_vals[i]) begin
            if ((i + 1) % k == 0) removed++;
            else kept.push_back(list_vals[i]);
          end
          list_vals = kept;
        end
      end
      default: ;
    endcase
    r.count = (cmd == CMD_KTH) ? COUNT_W'(removed) : COUNT_W'(list_vals.size());
    r.is_empty = (list_vals.size() == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got %0h expected %0h", result_count, what, got, want);
    error_count++;
  endtask

  // input side idle burst, with the item withdrawn
  task automatic idle_gap();
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // send one command and record its prediction
  task automatic send_command(logic [2:0] cmd, logic signed [31:0] v, logic [7:0] k);
    idle_gap();
    in_tdata  <= {5'd0, k, v, cmd};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_status.push_back(apply_command(cmd, v, k));
    cmd_count++;
  endtask

  // result receiver with random stall bursts
  always @(posedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (allow_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        stall_left <= int'($urandom_range(0, 3));
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    status_item_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[1:0], out_tdata[5:2], out_tdata[10:6], out_tdata[42:11],
             out_tdata[43]};
      if (pending_status.size() == 0) begin
        $display("MISMATCH unexpected result %0d", result_count);
        error_count++;
      end else begin
        want = pending_status.pop_front();
        if (got.status != want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.rank != want.rank)
          report_mismatch("rank", 32'(got.rank), 32'(want.rank));
        if (got.count != want.count)
          report_mismatch("count", 32'(got.count), 32'(want.count));
        if (got.out_value != want.out_value)
          report_mismatch("out_value", got.out_value, want.out_value);
        if (got.is_empty != want.is_empty)
          report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
      end
      result_count++;
    end
  end

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_order(logic desc);
    cfg_we    <= 1'b1;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_we <= 1'b0;
    descending = desc;
  endtask

  // value picker: small pool for frequent duplicates, sometimes full range or an extreme
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 12)) - 6;
    endcase
  endfunction

  task automatic test_directed();
    send_command(CMD_SIZE, 0, 0);
    send_command(CMD_SEARCH, 5, 0);
    send_command(CMD_REMOVE, 5, 0);
    send_command(CMD_KTH, 0, 2);
    send_command(CMD_INSERT, 32'sh7fffffff, 8'hff);
    send_command(CMD_INSERT, 32'sh80000000, 0);
    send_command(CMD_INSERT, 0, 0);
    send_command(CMD_INSERT, 0, 0);
    send_command(CMD_SEARCH, 32'sh7fffffff, 0);
    send_command(CMD_KTH, 0, 0);
    send_command(3'd5, 0, 0);
    send_command(3'd7, 32'hffffffff, 0);
    send_command(CMD_REMOVE, 32'sh7fffffff, 0);
    send_command(CMD_KTH, 0, 8'hff);
    send_command(CMD_KTH, 0, 1);
    send_command(CMD_INSERT, 9, 0);
    send_command(CMD_REMOVE, 9, 0);
    // fill past capacity: full status and wide rank
    for (int i = 0; i < CAP + 1; i++) send_command(CMD_INSERT, i, 0);
    send_command(CMD_SEARCH, 15, 0);
    send_command(CMD_KTH, 0, 3);
    drain();
  endtask

  task automatic test_random(int n, logic desc);
    logic [2:0] cmd;
    set_order(desc);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: cmd = CMD_INSERT;
        4, 5: cmd = CMD_REMOVE;
        6, 7: cmd = CMD_SEARCH;
        8: cmd = CMD_KTH;
        default: cmd = 3'($urandom_range(4, 7));
      endcase
      send_command(cmd, pick_value(),
                   cmd == CMD_KTH ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255)));
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(130, 1'b1);
    test_random(130, 1'b0);
    test_random(80, 1'b1);
    allow_idle = 1'b0;
    test_random(60, 1'b0);
    $display("Ran %0d commands in both orders, %0d results checked.", cmd_count,
             result_count);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding", pending_status.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
